// ===== sv/rvx_pkg.sv =====
// shared types, constants and instruction codes for the rv32i execute block
`default_nettype none
package rvx_pkg;

  // data memory, csr store, register file and result word sizes
  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned MEM_AW      = $clog2(MEM_BYTES);
  localparam int unsigned MEM_ROWS    = MEM_BYTES / 4;
  localparam int unsigned ROW_AW      = MEM_AW - 2;
  localparam int unsigned CSR_ENTRIES = 16;
  localparam int unsigned CSR_AW      = $clog2(CSR_ENTRIES);
  localparam int unsigned XLEN        = 32;
  localparam int unsigned NREGS       = 32;
  localparam int unsigned OUT_W       = 136;

  // major opcodes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // alu functions
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch conditions
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  // load and store widths
  localparam logic [2:0] LD_B  = 3'd0;
  localparam logic [2:0] LD_H  = 3'd1;
  localparam logic [2:0] LD_W  = 3'd2;
  localparam logic [2:0] LD_BU = 3'd4;
  localparam logic [2:0] LD_HU = 3'd5;
  localparam logic [1:0] SZ_B  = 2'd0;
  localparam logic [1:0] SZ_H  = 2'd1;
  localparam logic [1:0] SZ_W  = 2'd2;

  // system functions
  localparam logic [2:0] SYS_PRIV = 3'd0;
  localparam logic [2:0] SYS_RSV  = 3'd4;
  localparam logic [1:0] CSR_RW   = 2'd1;
  localparam logic [1:0] CSR_RS   = 2'd2;
  localparam logic [1:0] CSR_RC   = 2'd3;

  // outcome of one instruction
  typedef struct packed {
    logic [31:0] next_addr;
    logic        reg_wr;
    logic [4:0]  reg_num;
    logic [31:0] reg_val;
    logic        mem_wr;
    logic [31:0] mem_addr;
    logic [31:0] mem_val;
    logic        csr_wr;
    logic [31:0] csr_val;
  } exec_res_t;

endpackage
`default_nettype wire

// ===== sv/rvx_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`default_nettype none
module rvx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/rvx_dmem.sv =====
// byte-addressed data memory in four byte lanes with clearing pass after reset
`default_nettype none
module rvx_dmem (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [rvx_pkg::MEM_AW-1:0] rd_addr_i,
  input  wire logic                      wr_en_i,
  input  wire logic [rvx_pkg::MEM_AW-1:0] wr_addr_i,
  input  wire logic [1:0]                wr_size_i,
  input  wire logic [31:0]               wr_data_i,
  output logic      [31:0]               load_o,
  output logic                           busy_o
);

  localparam int unsigned RAW = rvx_pkg::ROW_AW;

  logic           clr_q;
  logic [RAW-1:0] clr_row_q;
  logic [1:0]     rd_off_q;
  logic [7:0]     lane_rd [4];

  // clearing sweep, one row of all four lanes per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else if (clr_q) begin
      clr_row_q <= clr_row_q + 1'b1;
      if (clr_row_q == RAW'(rvx_pkg::MEM_ROWS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // byte offset of the pending read, for reassembly
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_off_q <= rd_addr_i[1:0];
    end
  end

  // lanes: byte j of an access at A sits in lane (A+j)&3
  for (genvar gl = 0; gl < 4; gl++) begin : g_lane
    logic [RAW-1:0] rrow;
    logic [RAW-1:0] wrow;
    logic [1:0]     wj;
    logic           wsel;
    logic           we;
    logic [RAW-1:0] waddr;
    logic [7:0]     wdata;

    assign rrow = rd_addr_i[rvx_pkg::MEM_AW-1:2]
                + RAW'(2'(gl) < rd_addr_i[1:0]);
    assign wrow = wr_addr_i[rvx_pkg::MEM_AW-1:2]
                + RAW'(2'(gl) < wr_addr_i[1:0]);
    assign wj   = 2'(gl) - wr_addr_i[1:0];

    // lane takes part when its byte index lies within the store size
    always_comb begin
      case (wr_size_i)
        rvx_pkg::SZ_B: wsel = (wj == 2'd0);
        rvx_pkg::SZ_H: wsel = (wj <= 2'd1);
        default:       wsel = 1'b1;
      endcase
    end

    assign we    = clr_q || (wr_en_i && wsel);
    assign waddr = clr_q ? clr_row_q : wrow;
    assign wdata = clr_q ? 8'h00 : wr_data_i[8*wj +: 8];

    rvx_ram #(
      .WIDTH (8),
      .DEPTH (rvx_pkg::MEM_ROWS)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (rd_en_i),
      .raddr_i (rrow),
      .rdata_o (lane_rd[gl])
    );
  end

  // reassemble bytes in access order
  for (genvar gj = 0; gj < 4; gj++) begin : g_byte
    assign load_o[8*gj +: 8] = lane_rd[2'(rd_off_q + 2'(gj))];
  end

  assign busy_o = clr_q;

endmodule
`default_nettype wire

// ===== sv/rvx_exec.sv =====
// execute stage: decodes one instruction and works out its full outcome
`default_nettype none
module rvx_exec (
  input  wire logic [31:0]       ins_i,
  input  wire logic [31:0]       pc_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  input  wire logic [31:0]       addr_i,
  input  wire logic [31:0]       load_i,
  input  wire logic [31:0]       csr_old_i,
  output rvx_pkg::exec_res_t     res_o
);

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [4:0]  r1;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] alu_b;
  logic        alu_alt;
  logic [4:0]  sh;
  logic [31:0] alu_r;
  logic        take;
  logic [31:0] csr_src;
  logic [31:0] pc4;
  rvx_pkg::exec_res_t r;

  // instruction fields and immediates
  assign op    = ins_i[6:0];
  assign rd    = ins_i[11:7];
  assign f3    = ins_i[14:12];
  assign r1    = ins_i[19:15];
  assign alt   = ins_i[30];
  assign imm_i = {{20{ins_i[31]}}, ins_i[31:20]};
  assign imm_b = {{19{ins_i[31]}}, ins_i[31], ins_i[7], ins_i[30:25], ins_i[11:8], 1'b0};
  assign imm_j = {{11{ins_i[31]}}, ins_i[31], ins_i[19:12], ins_i[20], ins_i[30:21], 1'b0};
  assign pc4   = pc_i + 32'd4;

  // alu
  assign alu_b   = (op == rvx_pkg::OP_REG) ? b_i : imm_i;
  assign alu_alt = alt && ((f3 == rvx_pkg::F3_SR) ||
                   ((op == rvx_pkg::OP_REG) && (f3 == rvx_pkg::F3_ADD)));
  assign sh      = alu_b[4:0];

  always_comb begin
    unique case (f3)
      rvx_pkg::F3_ADD:  alu_r = alu_alt ? a_i - alu_b : a_i + alu_b;
      rvx_pkg::F3_SLL:  alu_r = a_i << sh;
      rvx_pkg::F3_SLT:  alu_r = {31'd0, $signed(a_i) < $signed(alu_b)};
      rvx_pkg::F3_SLTU: alu_r = {31'd0, a_i < alu_b};
      rvx_pkg::F3_XOR:  alu_r = a_i ^ alu_b;
      rvx_pkg::F3_SR:   alu_r = alu_alt ? $unsigned($signed(a_i) >>> sh) : a_i >> sh;
      rvx_pkg::F3_OR:   alu_r = a_i | alu_b;
      default:          alu_r = a_i & alu_b;
    endcase
  end

  // branch condition
  always_comb begin
    unique case (f3)
      rvx_pkg::BR_EQ:  take = (a_i == b_i);
      rvx_pkg::BR_NE:  take = (a_i != b_i);
      rvx_pkg::BR_LT:  take = $signed(a_i) < $signed(b_i);
      rvx_pkg::BR_GE:  take = $signed(a_i) >= $signed(b_i);
      rvx_pkg::BR_LTU: take = a_i < b_i;
      rvx_pkg::BR_GEU: take = a_i >= b_i;
      default:         take = 1'b0;
    endcase
  end

  assign csr_src = f3[2] ? {27'd0, r1} : a_i;

  // main decode
  always_comb begin
    r           = '0;
    r.next_addr = pc4;
    unique case (op)
      rvx_pkg::OP_LUI: begin
        r.reg_wr  = 1'b1;
        r.reg_val = {ins_i[31:12], 12'd0};
      end
      rvx_pkg::OP_AUIPC: begin
        r.reg_wr  = 1'b1;
        r.reg_val = pc_i + {ins_i[31:12], 12'd0};
      end
      rvx_pkg::OP_JAL: begin
        r.reg_wr    = 1'b1;
        r.reg_val   = pc4;
        r.next_addr = pc_i + imm_j;
      end
      rvx_pkg::OP_JALR: begin
        r.reg_wr    = 1'b1;
        r.reg_val   = pc4;
        r.next_addr = (a_i + imm_i) & 32'hffff_fffe;
      end
      rvx_pkg::OP_BRANCH: begin
        if (take) begin
          r.next_addr = pc_i + imm_b;
        end
      end
      rvx_pkg::OP_LOAD: begin
        case (f3)
          rvx_pkg::LD_B: begin
            r.reg_wr = 1'b1; r.mem_addr = addr_i;
            r.reg_val = {{24{load_i[7]}}, load_i[7:0]};
          end
          rvx_pkg::LD_H: begin
            r.reg_wr = 1'b1; r.mem_addr = addr_i;
            r.reg_val = {{16{load_i[15]}}, load_i[15:0]};
          end
          rvx_pkg::LD_W: begin
            r.reg_wr = 1'b1; r.mem_addr = addr_i;
            r.reg_val = load_i;
          end
          rvx_pkg::LD_BU: begin
            r.reg_wr = 1'b1; r.mem_addr = addr_i;
            r.reg_val = {24'd0, load_i[7:0]};
          end
          rvx_pkg::LD_HU: begin
            r.reg_wr = 1'b1; r.mem_addr = addr_i;
            r.reg_val = {16'd0, load_i[15:0]};
          end
          default: ;
        endcase
      end
      rvx_pkg::OP_STORE: begin
        if (f3[2] == 1'b0 && f3[1:0] != 2'd3) begin
          r.mem_wr   = 1'b1;
          r.mem_addr = addr_i;
          case (f3[1:0])
            rvx_pkg::SZ_B: r.mem_val = {24'd0, b_i[7:0]};
            rvx_pkg::SZ_H: r.mem_val = {16'd0, b_i[15:0]};
            default:       r.mem_val = b_i;
          endcase
        end
      end
      rvx_pkg::OP_IMM, rvx_pkg::OP_REG: begin
        r.reg_wr  = 1'b1;
        r.reg_val = alu_r;
      end
      rvx_pkg::OP_SYSTEM: begin
        if (f3 != rvx_pkg::SYS_PRIV && f3 != rvx_pkg::SYS_RSV) begin
          r.reg_wr  = 1'b1;
          r.reg_val = csr_old_i;
          case (f3[1:0])
            rvx_pkg::CSR_RW: begin
              r.csr_wr = 1'b1; r.csr_val = csr_src;
            end
            rvx_pkg::CSR_RS: begin
              r.csr_wr = (r1 != 5'd0); r.csr_val = csr_old_i | csr_src;
            end
            default: begin
              r.csr_wr = (r1 != 5'd0); r.csr_val = csr_old_i & ~csr_src;
            end
          endcase
        end
      end
      default: ;
    endcase

    // x0 is never written
    if (!r.reg_wr || rd == 5'd0) begin
      r.reg_wr  = 1'b0;
      r.reg_val = '0;
    end else begin
      r.reg_num = rd;
    end
  end

  assign res_o = r;

endmodule
`default_nettype wire

// ===== sv/rv32i_instruction_execute.sv =====
// top level of the rv32i execute block: register file, csr store, data memory, pipeline
// Each instruction word taken on the s_axis side gives one result word on the m_axis side,
// in order. An instruction passes a first stage, which reads rs1/rs2 from the register
// file RAMs and issues the data memory and csr reads, and a second stage, which executes
// and writes back. The next instruction is taken in the cycle its predecessor writes back,
// not before; the register file and data memory are synchronous with registered reads. A
// stalled result holds the pipeline only while the output register is full. After reset
// the data memory is zeroed by a sweep over its MEM_BYTES/4 rows (1024 at the default
// size) during which no instruction is taken; the start address may be written at any
// idle time and loads the program counter.
`default_nettype none
module rv32i_instruction_execute (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // start address write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  // instruction words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // instruction_word
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_address[31:0], reg_written[32], reg_number[37:33], reg_value[69:38],
  // mem_written[70], mem_address[102:71], mem_value[134:103], zero pad[135]
  output logic [rvx_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned CAW = rvx_pkg::CSR_AW;

  logic        accept;
  logic        clr_busy;
  logic [31:0] pc_q;

  // register file bookkeeping
  logic [rvx_pkg::NREGS-1:0] rf_ok_q;
  logic        rs1_ok_q, rs2_ok_q;
  logic        wb_v_q;
  logic [4:0]  wb_rd_q;
  logic [31:0] wb_val_q;
  logic [31:0] rf_rd1, rf_rd2;

  // csr bookkeeping
  logic [rvx_pkg::CSR_ENTRIES-1:0] csr_ok_q;
  logic [31:0] csr_rd;

  // first stage
  logic        s1_v_q;
  logic [31:0] s1_ins_q;
  logic [31:0] s1_a, s1_b, s1_addr;

  // second stage
  logic        s2_v_q;
  logic [31:0] s2_ins_q, s2_a_q, s2_b_q, s2_addr_q;
  logic        s2_go, s2_fire;
  logic [31:0] load_word;
  logic [31:0] csr_old;
  rvx_pkg::exec_res_t res;

  // output register
  logic                      out_v_q;
  logic [rvx_pkg::OUT_W-1:0] out_q;

  assign s2_go         = !out_v_q || m_axis_tready;
  assign s2_fire       = s2_v_q && s2_go;
  assign s_axis_tready = !clr_busy && !s1_v_q && (!s2_v_q || s2_go);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // register file, one copy per read port
  rvx_ram #(.WIDTH (32), .DEPTH (rvx_pkg::NREGS)) u_rf1 (
    .clk_i   (clk_i),
    .we_i    (s2_fire && res.reg_wr),
    .waddr_i (res.reg_num),
    .wdata_i (res.reg_val),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[19:15]),
    .rdata_o (rf_rd1)
  );

  rvx_ram #(.WIDTH (32), .DEPTH (rvx_pkg::NREGS)) u_rf2 (
    .clk_i   (clk_i),
    .we_i    (s2_fire && res.reg_wr),
    .waddr_i (res.reg_num),
    .wdata_i (res.reg_val),
    .re_i    (accept),
    .raddr_i (s_axis_tdata[24:20]),
    .rdata_o (rf_rd2)
  );

  // valid bits and last write-back for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_ok_q  <= '0;
      csr_ok_q <= '0;
      wb_v_q   <= 1'b0;
    end else if (s2_fire) begin
      if (res.reg_wr) begin
        rf_ok_q[res.reg_num] <= 1'b1;
        wb_v_q               <= 1'b1;
      end
      if (res.csr_wr) begin
        csr_ok_q[s2_ins_q[20 +: CAW]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && res.reg_wr) begin
      wb_rd_q  <= res.reg_num;
      wb_val_q <= res.reg_val;
    end
    if (accept) begin
      rs1_ok_q <= rf_ok_q[s_axis_tdata[19:15]];
      rs2_ok_q <= rf_ok_q[s_axis_tdata[24:20]];
      s1_ins_q <= s_axis_tdata;
    end
  end

  // operands with forwarding of a write-back at the read edge, and the memory address
  always_comb begin
    if (wb_v_q && wb_rd_q == s1_ins_q[19:15]) begin
      s1_a = wb_val_q;
    end else begin
      s1_a = rs1_ok_q ? rf_rd1 : 32'd0;
    end
    if (wb_v_q && wb_rd_q == s1_ins_q[24:20]) begin
      s1_b = wb_val_q;
    end else begin
      s1_b = rs2_ok_q ? rf_rd2 : 32'd0;
    end
    if (s1_ins_q[6:0] == rvx_pkg::OP_STORE) begin
      s1_addr = s1_a + {{20{s1_ins_q[31]}}, s1_ins_q[31:25], s1_ins_q[11:7]};
    end else begin
      s1_addr = s1_a + {{20{s1_ins_q[31]}}, s1_ins_q[31:20]};
    end
  end

  // data memory
  rvx_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_v_q),
    .rd_addr_i (s1_addr[rvx_pkg::MEM_AW-1:0]),
    .wr_en_i   (s2_fire && res.mem_wr),
    .wr_addr_i (s2_addr_q[rvx_pkg::MEM_AW-1:0]),
    .wr_size_i (s2_ins_q[13:12]),
    .wr_data_i (s2_b_q),
    .load_o    (load_word),
    .busy_o    (clr_busy)
  );

  // csr store
  rvx_ram #(.WIDTH (32), .DEPTH (rvx_pkg::CSR_ENTRIES)) u_csr (
    .clk_i   (clk_i),
    .we_i    (s2_fire && res.csr_wr),
    .waddr_i (s2_ins_q[20 +: CAW]),
    .wdata_i (res.csr_val),
    .re_i    (s1_v_q),
    .raddr_i (s1_ins_q[20 +: CAW]),
    .rdata_o (csr_rd)
  );

  assign csr_old = csr_ok_q[s2_ins_q[20 +: CAW]] ? csr_rd : 32'd0;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_ins_q  <= s1_ins_q;
      s2_a_q    <= s1_a;
      s2_b_q    <= s1_b;
      s2_addr_q <= s1_addr;
    end
  end

  rvx_exec u_exec (
    .ins_i     (s2_ins_q),
    .pc_i      (pc_q),
    .a_i       (s2_a_q),
    .b_i       (s2_b_q),
    .addr_i    (s2_addr_q),
    .load_i    (load_word),
    .csr_old_i (csr_old),
    .res_o     (res)
  );

  // program counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (cfg_valid_i) begin
      pc_q <= cfg_data_i;
    end else if (s2_fire) begin
      pc_q <= res.next_addr;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_fire) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_q <= {1'b0, res.mem_val, res.mem_addr, res.mem_wr, res.reg_val,
                res.reg_num, res.reg_wr, res.next_addr};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_v_q && s2_v_q))
    else $error("two instructions inside at once");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |=> s2_v_q)
    else $error("first stage did not advance");

  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !clr_busy)
    else $error("instruction taken during memory clear");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> out_v_q)
    else $error("executed result not presented");
`endif

endmodule
`default_nettype wire
